[rtl/core/bpf_pkg.sv]
// ----------------------------------------------------------------------------
// bpf_pkg: shared types, constants and helpers for the branch power flow block
// Holds the item structs, the arctangent table and the stage widths.
// ----------------------------------------------------------------------------
`default_nettype none
package bpf_pkg;

  localparam int CordicSteps = 16;
  localparam int SqrtSteps   = 32;
  localparam int StepW       = 5;

  localparam logic signed [17:0] AngPi     = 18'sd25736;
  localparam logic signed [17:0] AngTwoPi  = 18'sd51472;
  localparam logic signed [17:0] AngHalfPi = 18'sd12868;
  localparam logic signed [35:0] CordicGain = 36'sd652032874;

  typedef struct packed {
    logic signed [23:0] g_from_from;
    logic signed [23:0] b_from_from;
    logic signed [23:0] g_from_to;
    logic signed [23:0] b_from_to;
    logic signed [23:0] g_to_from;
    logic signed [23:0] b_to_from;
    logic signed [23:0] g_to_to;
    logic signed [23:0] b_to_to;
    logic        [15:0] vmag_from;
    logic signed [15:0] vang_from;
    logic        [15:0] vmag_to;
    logic signed [15:0] vang_to;
  } bpf_in_t;

  typedef struct packed {
    logic signed [31:0] p_from;
    logic signed [31:0] q_from;
    logic signed [31:0] p_to;
    logic signed [31:0] q_to;
    logic        [30:0] s_from;
    logic        [30:0] s_to;
  } bpf_out_t;

  // Carried along the CORDIC chain
  typedef struct packed {
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [21:0] z;
    logic               neg;
    bpf_in_t            line;
  } bpf_rot_t;

  // Carried along the square root chain
  typedef struct packed {
    logic [63:0] vf;
    logic [63:0] res;
    logic [63:0] vt;
    logic [63:0] rest;
    logic signed [31:0] p_from;
    logic signed [31:0] q_from;
    logic signed [31:0] p_to;
    logic signed [31:0] q_to;
  } bpf_sq_t;

  function automatic logic signed [21:0] atan_q16(input logic [StepW-1:0] i);
    logic signed [21:0] r;
    begin
      unique case (i)
        5'd0: r = 22'sd51472;  5'd1: r = 22'sd30386;
        5'd2: r = 22'sd16055;  5'd3: r = 22'sd8150;
        5'd4: r = 22'sd4091;   5'd5: r = 22'sd2047;
        5'd6: r = 22'sd1024;   5'd7: r = 22'sd512;
        5'd8: r = 22'sd256;    5'd9: r = 22'sd128;
        5'd10: r = 22'sd64;    5'd11: r = 22'sd32;
        5'd12: r = 22'sd16;    5'd13: r = 22'sd8;
        5'd14: r = 22'sd4;     5'd15: r = 22'sd2;
        default: r = 22'sd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    begin
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      else if (v < -64'sd2147483648) return 32'sh80000000;
      else return v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

[rtl/core/bpf_cordic_cell.sv]
// ----------------------------------------------------------------------------
// bpf_cordic_cell: one CORDIC rotation step
// Rotates by the table angle of its own index and registers the vector.
// ----------------------------------------------------------------------------
`default_nettype none
module bpf_cordic_cell
  import bpf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic [StepW-1:0] idx,
  input  wire logic             in_vld,
  input  wire bpf_rot_t         in_d,
  output logic                  out_vld,
  output bpf_rot_t              out_d
);
  bpf_rot_t nxt;
  logic signed [35:0] dx, dy;

  always_comb begin
    dx  = in_d.y >>> idx;
    dy  = in_d.x >>> idx;
    nxt = in_d;
    if (!in_d.z[21]) begin
      nxt.x = in_d.x - dx;
      nxt.y = in_d.y + dy;
      nxt.z = in_d.z - atan_q16(idx);
    end else begin
      nxt.x = in_d.x + dx;
      nxt.y = in_d.y - dy;
      nxt.z = in_d.z + atan_q16(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
    if (en) begin
      out_d <= nxt;
    end
  end
endmodule
`default_nettype wire

[rtl/core/bpf_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// bpf_sqrt_cell: one digit of two integer square roots
// Trial bit one is 2^(62-2*idx); both ends advance together.
// ----------------------------------------------------------------------------
`default_nettype none
module bpf_sqrt_cell
  import bpf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic [StepW-1:0] idx,
  input  wire logic             in_vld,
  input  wire bpf_sq_t          in_d,
  output logic                  out_vld,
  output bpf_sq_t               out_d
);
  bpf_sq_t nxt;
  logic [63:0] one;

  // Leading zero trial bits leave res at zero, so starting at 2^62 matches
  always_comb begin
    one = 64'h4000_0000_0000_0000 >> {idx, 1'b0};
    nxt = in_d;
    if (in_d.vf >= in_d.res + one) begin
      nxt.vf  = in_d.vf - (in_d.res + one);
      nxt.res = (in_d.res >> 1) + one;
    end else begin
      nxt.res = in_d.res >> 1;
    end
    if (in_d.vt >= in_d.rest + one) begin
      nxt.vt   = in_d.vt - (in_d.rest + one);
      nxt.rest = (in_d.rest >> 1) + one;
    end else begin
      nxt.rest = in_d.rest >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
    if (en) begin
      out_d <= nxt;
    end
  end
endmodule
`default_nettype wire

[rtl/core/branch_power_flow_polar.sv]
// ----------------------------------------------------------------------------
// branch_power_flow_polar: AC line power flow in polar form
// One line in, four powers and two apparent powers out, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one line item (bpf_in_t); out_valid/out_ready
//   carry one result item (bpf_out_t). An item moves when valid and ready
//   are both high at a rising edge of clk.
//   Stages in order: angle wrap and fold, a chain of 16 CORDIC
//   cells, magnitude products, cross products and self terms,
//   scaling and multiply by VV, power sum and saturation, squares
//   and sum of squares, a chain of 32 square root cells and the
//   output register.
//   Throughput is one item per clock unless stalled: each cell and stage
//   takes a new item every cycle. The pipeline advances as one; when the
//   receiver stalls with the output register full, every stage holds and
//   in_ready drops, while a free output register lets it move on.
//   rst is synchronous, active high, and clears every stage valid bit;
//   payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
module branch_power_flow_polar
  import bpf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire bpf_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output bpf_out_t      out_data
);
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage A: wrap and fold the angle difference
  logic signed [17:0] d_raw, d_wrap, d_fold;
  logic               d_neg;
  always_comb begin
    d_raw = {{2{in_data.vang_from[15]}}, in_data.vang_from}
          - {{2{in_data.vang_to[15]}}, in_data.vang_to};
    d_wrap = d_raw;
    if (d_raw > AngPi) d_wrap = d_raw - AngTwoPi;
    else if (d_raw < -AngPi) d_wrap = d_raw + AngTwoPi;
    d_fold = d_wrap;
    d_neg  = 1'b0;
    if (d_wrap > AngHalfPi) begin
      d_fold = d_wrap - AngPi; d_neg = 1'b1;
    end else if (d_wrap < -AngHalfPi) begin
      d_fold = d_wrap + AngPi; d_neg = 1'b1;
    end
  end

  logic     a_vld;
  bpf_rot_t a_d;
  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (en) a_vld <= in_valid;
    if (en) begin
      a_d.x    <= CordicGain;
      a_d.y    <= '0;
      a_d.z    <= {{4{d_fold[17]}}, d_fold} <<< 3;
      a_d.neg  <= d_neg;
      a_d.line <= in_data;
    end
  end

  // CORDIC chain
  logic     rv [CordicSteps+1];
  bpf_rot_t rd [CordicSteps+1];
  assign rv[0] = a_vld;
  assign rd[0] = a_d;
  for (genvar i = 0; i < CordicSteps; i++) begin : g_rot
    bpf_cordic_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .idx(StepW'(i)),
      .in_vld(rv[i]), .in_d(rd[i]), .out_vld(rv[i+1]), .out_d(rd[i+1])
    );
  end

  // Stage B: cos/sin in Q2.16, magnitude products
  bpf_rot_t rl;
  assign rl = rd[CordicSteps];
  logic signed [21:0] c_raw, s_raw;
  assign c_raw = 22'(rl.x >>> 14);
  assign s_raw = 22'(rl.y >>> 14);

  logic               b_vld;
  logic signed [21:0] b_c, b_s;
  logic signed [21:0] b_vff, b_vtt, b_vv;
  bpf_in_t            b_l;
  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else if (en) b_vld <= rv[CordicSteps];
    if (en) begin
      b_c   <= rl.neg ? -c_raw : c_raw;
      b_s   <= rl.neg ? -s_raw : s_raw;
      b_vff <= 22'((32'(rl.line.vmag_from) * 32'(rl.line.vmag_from)) >> 12);
      b_vtt <= 22'((32'(rl.line.vmag_to) * 32'(rl.line.vmag_to)) >> 12);
      b_vv  <= 22'((32'(rl.line.vmag_from) * 32'(rl.line.vmag_to)) >> 12);
      b_l   <= rl.line;
    end
  end

  // Stage C: admittance times trig, self terms
  logic signed [46:0] c_gftc, c_bfts, c_bftc, c_gfts;
  logic signed [46:0] c_gtfc, c_btfs, c_btfc, c_gtfs;
  logic signed [47:0] c_sfp, c_sfq, c_stp, c_stq;
  logic               c_vld;
  logic signed [21:0] c_vv;
  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else if (en) c_vld <= b_vld;
    if (en) begin
      c_gftc <= b_l.g_from_to * b_c;  c_bfts <= b_l.b_from_to * b_s;
      c_bftc <= b_l.b_from_to * b_c;  c_gfts <= b_l.g_from_to * b_s;
      c_gtfc <= b_l.g_to_from * b_c;  c_btfs <= b_l.b_to_from * b_s;
      c_btfc <= b_l.b_to_from * b_c;  c_gtfs <= b_l.g_to_from * b_s;
      c_sfp  <= b_l.g_from_from * b_vff;
      c_sfq  <= -(48'(b_l.b_from_from) * 48'(b_vff));
      c_stp  <= b_l.g_to_to * b_vtt;
      c_stq  <= -(48'(b_l.b_to_to) * 48'(b_vtt));
      c_vv   <= b_vv;
    end
  end

  // Stage D: cross sums scaled, times VV
  logic signed [36:0] xfp, xfq, xtp, xtq;
  assign xfp = 37'((48'(c_gftc) + 48'(c_bfts)) >>> 12);
  assign xfq = 37'((-48'(c_bftc) + 48'(c_gfts)) >>> 12);
  assign xtp = 37'((48'(c_gtfc) - 48'(c_btfs)) >>> 12);
  assign xtq = 37'((-48'(c_btfc) - 48'(c_gtfs)) >>> 12);

  logic               d_vld;
  logic signed [63:0] d_xfp, d_xfq, d_xtp, d_xtq;
  logic signed [47:0] d_sfp, d_sfq, d_stp, d_stq;
  always_ff @(posedge clk) begin
    if (rst) d_vld <= 1'b0;
    else if (en) d_vld <= c_vld;
    if (en) begin
      d_xfp <= 64'(xfp) * 64'(c_vv);  d_xfq <= 64'(xfq) * 64'(c_vv);
      d_xtp <= 64'(xtp) * 64'(c_vv);  d_xtq <= 64'(xtq) * 64'(c_vv);
      d_sfp <= c_sfp; d_sfq <= c_sfq; d_stp <= c_stp; d_stq <= c_stq;
    end
  end

  // Stage E: sum, shift and saturate
  logic               e_vld;
  logic signed [31:0] e_pf, e_qf, e_pt, e_qt;
  always_ff @(posedge clk) begin
    if (rst) e_vld <= 1'b0;
    else if (en) e_vld <= d_vld;
    if (en) begin
      e_pf <= sat32(((64'(d_sfp) <<< 4) + d_xfp) >>> 16);
      e_qf <= sat32(((64'(d_sfq) <<< 4) + d_xfq) >>> 16);
      e_pt <= sat32(((64'(d_stp) <<< 4) + d_xtp) >>> 16);
      e_qt <= sat32(((64'(d_stq) <<< 4) + d_xtq) >>> 16);
    end
  end

  // Stage F: squares and sums, taken at full 64-bit width
  logic    f_vld;
  bpf_sq_t f_d;
  always_ff @(posedge clk) begin
    if (rst) f_vld <= 1'b0;
    else if (en) f_vld <= e_vld;
    if (en) begin
      f_d.vf   <= (64'(e_pf) * 64'(e_pf)) + (64'(e_qf) * 64'(e_qf));
      f_d.vt   <= (64'(e_pt) * 64'(e_pt)) + (64'(e_qt) * 64'(e_qt));
      f_d.res  <= '0;
      f_d.rest <= '0;
      f_d.p_from <= e_pf; f_d.q_from <= e_qf;
      f_d.p_to   <= e_pt; f_d.q_to   <= e_qt;
    end
  end

  // Square root chain
  logic    sv [SqrtSteps+1];
  bpf_sq_t sd [SqrtSteps+1];
  assign sv[0] = f_vld;
  assign sd[0] = f_d;
  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sq
    bpf_sqrt_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .idx(StepW'(j)),
      .in_vld(sv[j]), .in_d(sd[j]), .out_vld(sv[j+1]), .out_d(sd[j+1])
    );
  end

  // Output register
  bpf_sq_t sl;
  assign sl = sd[SqrtSteps];
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= sv[SqrtSteps];
    if (en) begin
      out_data.p_from <= sl.p_from;
      out_data.q_from <= sl.q_from;
      out_data.p_to   <= sl.p_to;
      out_data.q_to   <= sl.q_to;
      out_data.s_from <= (sl.res[63:31] != '0) ? 31'h7fffffff : sl.res[30:0];
      out_data.s_to   <= (sl.rest[63:31] != '0) ? 31'h7fffffff : sl.rest[30:0];
    end
  end

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready out of step with output register");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.p_from == 32'sd0 && out_data.q_from == 32'sd0
      |-> out_data.s_from == 31'd0)
    else $error("apparent power nonzero for zero powers");
endmodule
`default_nettype wire
